### rtl/pfd_pkg.sv
// Shared types and constants for the pose frame deframer.
package pfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PAYLOAD_LEN = 12;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam byte_t CH_CR = 8'h0d;
  localparam byte_t CH_LF = 8'h0a;

  typedef enum logic [2:0] {
    PH_HUNT_CR = 3'd0,
    PH_WAIT_LF = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_END_LF  = 3'd3,
    PH_END_CR  = 3'd4
  } phase_e;

  typedef struct packed {
    logic shift;
    logic emit;
  } ctl_t;

endpackage

### rtl/pfd_if.sv
// Valid/ready channel interfaces for received bytes and decoded frames.
interface pfd_rx_if
  import pfd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfd_res_if
  import pfd_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t angle_bits;
  word_t x_bits;
  word_t y_bits;

  modport source (output valid, output angle_bits, output x_bits, output y_bits, input ready);
  modport sink   (input valid, input angle_bits, input x_bits, input y_bits, output ready);
endinterface

### rtl/pfd_cell.sv
// One byte cell of the payload shift chain.
module pfd_cell
  import pfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  byte_t byte_i,
  output byte_t byte_o
);

  byte_t byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

### rtl/pfd_ctrl.sv
// Frame hunt state machine and payload byte counter.
module pfd_ctrl
  import pfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  byte_t rx_byte_i,
  output ctl_t  ctl_o
);

  phase_e phase_q, phase_d;
  idx_t   idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT_CR;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    ctl_o.shift = 1'b0;
    ctl_o.emit  = 1'b0;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT_CR: begin
          phase_d = (rx_byte_i == CH_CR) ? PH_WAIT_LF : PH_HUNT_CR;
        end
        PH_WAIT_LF: begin
          // stay put on repeated CR
          if (rx_byte_i == CH_LF) begin
            idx_d   = '0;
            phase_d = PH_PAYLOAD;
          end else if (rx_byte_i != CH_CR) begin
            phase_d = PH_HUNT_CR;
          end
        end
        PH_PAYLOAD: begin
          ctl_o.shift = 1'b1;
          if (idx_q == IDX_W'(PAYLOAD_LEN - 1)) begin
            idx_d   = '0;
            phase_d = PH_END_LF;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PH_END_LF: begin
          phase_d = (rx_byte_i == CH_LF) ? PH_END_CR : PH_HUNT_CR;
        end
        PH_END_CR: begin
          ctl_o.emit = (rx_byte_i == CH_CR);
          phase_d    = PH_HUNT_CR;
        end
        default: begin
          phase_d = PH_HUNT_CR;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_PAYLOAD) |-> (idx_q == '0))
    else $error("payload index nonzero outside payload phase");

  a_end_cr_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $changed(phase_q) && (phase_q == PH_END_CR) |-> ($past(phase_q) == PH_END_LF))
    else $error("closing CR phase entered from wrong phase");
`endif

endmodule

### rtl/pose_frame_deframer.sv
// A frame's words reach res_o in the cycle after its closing CR is taken.
// Throughput: one received byte per cycle; the input stalls only when a result
// is pending in the output register and the sink holds it off.
// Reset: clears the hunt phase, payload counter and output valid; the payload
// shift chain and output words are not reset.
module pose_frame_deframer
  import pfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pfd_rx_if.sink       rx_i,
  pfd_res_if.source    res_o
);

  ctl_t  ctl;
  logic  rx_accept;
  logic  out_valid_q, out_valid_d;
  word_t angle_q, x_q, y_q;
  byte_t cell_in   [PAYLOAD_LEN];
  byte_t cell_byte [PAYLOAD_LEN];

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_accept  = rx_i.valid && rx_i.ready;

  pfd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (rx_accept),
    .rx_byte_i (rx_i.rx_byte),
    .ctl_o     (ctl)
  );

  // New bytes enter at the top cell and walk down, so cell 0 ends up with byte 0.
  for (genvar i = 0; i < PAYLOAD_LEN; i++) begin : g_cell
    if (i == PAYLOAD_LEN - 1) begin : g_head
      assign cell_in[i] = rx_i.rx_byte;
    end else begin : g_link
      assign cell_in[i] = cell_byte[i+1];
    end
    pfd_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctl.shift),
      .byte_i  (cell_in[i]),
      .byte_o  (cell_byte[i])
    );
  end

  assign out_valid_d = ctl.emit || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      angle_q <= {cell_byte[3], cell_byte[2], cell_byte[1], cell_byte[0]};
      x_q     <= {cell_byte[7], cell_byte[6], cell_byte[5], cell_byte[4]};
      y_q     <= {cell_byte[11], cell_byte[10], cell_byte[9], cell_byte[8]};
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.angle_bits = angle_q;
  assign res_o.x_bits     = x_q;
  assign res_o.y_bits     = y_q;

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> (!out_valid_q || res_o.ready))
    else $error("result emitted while output register still full");

  a_rise_after_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(rx_accept && (rx_i.rx_byte == CH_CR)))
    else $error("output valid rose without an accepted closing CR");

  a_no_shift_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> !ctl.shift)
    else $error("payload chain shifted during emit");
`endif

endmodule

### sim/tb.sv
// Testbench for pose_frame_deframer: byte-stream stimulus, frame prediction and word checks.
`timescale 1ns / 1ps

module tb;
  import pfd_pkg::*;

  localparam int RANDOM_BYTES  = 550;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLDOFF_LEN   = 240;
  localparam int DRAIN_CYCLES  = 4;
  localparam int MAX_PRINTS    = 40;

  typedef byte_t payload_t [PAYLOAD_LEN];
  typedef byte_t byte_q_t [$];

  typedef struct packed {
    word_t angle_bits;
    word_t x_bits;
    word_t y_bits;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfd_rx_if  rx_ch ();
  pfd_res_if res_ch ();

  pose_frame_deframer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  always #10 clk = ~clk;

  // Frame tracker state, mirrors the hunt machine.
  phase_e rx_phase   = PH_HUNT_CR;
  idx_t   slot       = '0;
  byte_t  payload_seen [PAYLOAD_LEN];
  pose_t  pending_poses [$];

  bit rx_idle_en     = 1'b1;
  bit sink_idle_en   = 1'b1;
  int holdoff_cycles = 0;
  int errors         = 0;
  int bytes_taken    = 0;
  int poses_checked  = 0;

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic void track_rx_byte(input byte_t b);
    pose_t p;
    case (rx_phase)
      PH_HUNT_CR: rx_phase = (b == CH_CR) ? PH_WAIT_LF : PH_HUNT_CR;
      PH_WAIT_LF: begin
        if (b == CH_LF) begin
          slot     = '0;
          rx_phase = PH_PAYLOAD;
        end else if (b != CH_CR) begin
          rx_phase = PH_HUNT_CR;
        end
      end
      PH_PAYLOAD: begin
        if (slot < PAYLOAD_LEN) payload_seen[slot] = b;
        slot = slot + 1'b1;
        if (slot >= PAYLOAD_LEN || slot == 0) begin
          slot     = '0;
          rx_phase = PH_END_LF;
        end
      end
      PH_END_LF: rx_phase = (b == CH_LF) ? PH_END_CR : PH_HUNT_CR;
      PH_END_CR: begin
        if (b == CH_CR) begin
          p.angle_bits = {payload_seen[3], payload_seen[2], payload_seen[1], payload_seen[0]};
          p.x_bits     = {payload_seen[7], payload_seen[6], payload_seen[5], payload_seen[4]};
          p.y_bits     = {payload_seen[11], payload_seen[10], payload_seen[9], payload_seen[8]};
          pending_poses.push_back(p);
        end
        rx_phase = PH_HUNT_CR;
      end
      default: rx_phase = PH_HUNT_CR;
    endcase
  endfunction

  function automatic byte_q_t frame_bytes(input payload_t p);
    byte_q_t q;
    q = {CH_CR, CH_LF};
    foreach (p[i]) q.push_back(p[i]);
    q.push_back(CH_LF);
    q.push_back(CH_CR);
    return q;
  endfunction

  // Lean toward delimiter values so payload bytes that look like framing show up often.
  function automatic payload_t random_payload();
    payload_t p;
    foreach (p[i]) begin
      case ($urandom_range(7))
        0:       p[i] = CH_CR;
        1:       p[i] = CH_LF;
        default: p[i] = byte_t'($urandom);
      endcase
    end
    return p;
  endfunction

  task automatic send_byte(input byte_t b);
    while (rx_idle_en && $urandom_range(99) < 38) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= byte_t'($urandom);
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    track_rx_byte(b);
    bytes_taken++;
  endtask

  task automatic send_seq(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic test_directed_frames();
    payload_t p;
    byte_q_t  q;
    send_seq(frame_bytes('{default: 8'h00}));
    send_seq(frame_bytes('{default: 8'hff}));
    foreach (p[i]) p[i] = byte_t'(i * 17);
    send_seq(frame_bytes(p));
    // Payload made only of delimiter values must be taken as data.
    foreach (p[i]) p[i] = i[0] ? CH_LF : CH_CR;
    send_seq(frame_bytes(p));
    // Stray LF while hunting, then repeated CR before the opening LF.
    send_byte(CH_LF);
    q = frame_bytes('{default: 8'h55});
    q.push_front(CH_CR);
    q.push_front(CH_CR);
    send_seq(q);
    // Bad opening LF, then a clean frame.
    send_seq({CH_CR, 8'h0b});
    send_seq(frame_bytes('{default: 8'haa}));
    // Bad closing LF.
    q = frame_bytes(random_payload());
    q[14] = CH_CR;
    send_seq(q);
    // Bad final byte, then a frame right behind it.
    q = frame_bytes(random_payload());
    q[15] = CH_LF;
    send_seq(q);
    send_seq(frame_bytes(random_payload()));
  endtask

  task automatic test_random_traffic();
    int      framed;
    int      kind;
    int      pos;
    byte_t   v;
    byte_q_t q;
    framed = 0;
    while (framed < RANDOM_BYTES) begin
      kind = $urandom_range(19);
      q    = frame_bytes(random_payload());
      if (kind == 19) begin
        // Line noise between frames.
        repeat ($urandom_range(6, 1)) send_byte(byte_t'($urandom));
      end else begin
        if (kind >= 14 && kind <= 15) begin
          repeat ($urandom_range(3, 1)) q.push_front(CH_CR);
        end else if (kind >= 16 && kind <= 17) begin
          pos = $urandom_range(3);
          if (pos >= 2) pos += 12;
          do v = byte_t'($urandom); while (v == q[pos]);
          q[pos] = v;
        end else if (kind == 18) begin
          q = q[0:$urandom_range(14, 1)];
        end
        framed += q.size();
        send_seq(q);
      end
    end
  endtask

  task automatic test_no_idle();
    rx_idle_en   = 1'b0;
    sink_idle_en = 1'b0;
    repeat (25) send_seq(frame_bytes(random_payload()));
    rx_idle_en   = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Sink holds off while frames keep coming, so the output register fills.
  task automatic test_sink_holdoff();
    rx_idle_en     = 1'b0;
    holdoff_cycles = HOLDOFF_LEN;
    repeat (4) send_seq(frame_bytes(random_payload()));
    rx_idle_en     = 1'b1;
  endtask

  initial begin : sink_ready
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (holdoff_cycles) @(posedge clk);
        holdoff_cycles = 0;
      end
      res_ch.ready <= !sink_idle_en || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin : check_results
    pose_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_poses.size() == 0) begin
        flag_mismatch($sformatf("result with no frame pending: %h %h %h",
                                res_ch.angle_bits, res_ch.x_bits, res_ch.y_bits));
      end else begin
        want = pending_poses.pop_front();
        poses_checked++;
        if (res_ch.angle_bits !== want.angle_bits)
          flag_mismatch($sformatf("angle_bits got %h want %h", res_ch.angle_bits,
                                  want.angle_bits));
        if (res_ch.x_bits !== want.x_bits)
          flag_mismatch($sformatf("x_bits got %h want %h", res_ch.x_bits, want.x_bits));
        if (res_ch.y_bits !== want.y_bits)
          flag_mismatch($sformatf("y_bits got %h want %h", res_ch.y_bits, want.y_bits));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_traffic();
    test_no_idle();
    test_sink_holdoff();
    test_random_traffic();

    rx_ch.valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_poses.size() != 0)
      flag_mismatch($sformatf("%0d frames never delivered", pending_poses.size()));

    $display("Summary: %0d bytes taken, %0d decoded frames compared", bytes_taken,
             poses_checked);
    $display("Covered clean, delimiter-heavy, broken and truncated frames, noise,");
    $display("and a long sink hold-off");
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### pose_frame_deframer.f
rtl/pfd_pkg.sv
rtl/pfd_if.sv
rtl/pfd_cell.sv
rtl/pfd_ctrl.sv
rtl/pose_frame_deframer.sv
sim/tb.sv
